### rtl/mkte_pkg.sv
`default_nettype none
package mkte_pkg;

  // Message store size; write_addr and cursor widths are sized for it.
  localparam logic [9:0] MSG_SIZE = 10'd512;

  // Key codes
  localparam logic [4:0] KEY_NONE  = 5'd0;
  localparam logic [4:0] KEY_DIG0  = 5'd1;
  localparam logic [4:0] KEY_DIG9  = 5'd10;
  localparam logic [4:0] KEY_A     = 5'd11;
  localparam logic [4:0] KEY_B     = 5'd12;
  localparam logic [4:0] KEY_C     = 5'd13;
  localparam logic [4:0] KEY_D     = 5'd14;
  localparam logic [4:0] KEY_STAR  = 5'd15;
  localparam logic [4:0] KEY_HASH  = 5'd16;
  localparam logic [4:0] SPEED_TOP = 5'd11;

  // View modes
  localparam logic [1:0] VIEW_STATIC = 2'd0;
  localparam logic [1:0] VIEW_PAGING = 2'd1;
  localparam logic [1:0] VIEW_SCROLL = 2'd2;
  localparam logic [1:0] VIEW_ROTATE = 2'd3;

  // Cursor styles
  localparam logic [1:0] CUR_OFF    = 2'd0;
  localparam logic [1:0] CUR_BLINK  = 2'd1;
  localparam logic [1:0] CUR_STEADY = 2'd2;

  localparam logic [3:0]  SPEED_RESET   = 4'd5;
  localparam logic [15:0] TIMEOUT_RESET = 16'd750;

  // Register map
  localparam logic REG_PRESS_TIMEOUT = 1'b0;

  // Characters
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] DIGIT_BASE = 8'h30;
  localparam logic [7:0] UPPER_BASE = 8'h41;
  localparam logic [7:0] LOWER_BASE = 8'h61;

  // Number of letters/symbols before the digit itself, per digit key
  localparam logic [3:0] KEY_SPAN [10] = '{4'd2, 4'd10, 4'd3, 4'd3, 4'd3,
                                           4'd3, 4'd3, 4'd4, 4'd3, 4'd4};

  localparam logic [7:0] ONE_SYMBOLS [10] = '{8'h2E, 8'h2C, 8'h3F, 8'h21, 8'h2D,
                                              8'h28, 8'h29, 8'h2F, 8'h27, 8'h22};

  // First letter of each letter key relative to 'a' (keys 2..9; 7 and 9 have four)
  localparam logic [7:0] LETTER_OFFSET [10] = '{8'd0, 8'd0, 8'd0, 8'd3, 8'd6,
                                                8'd9, 8'd12, 8'd15, 8'd19, 8'd22};

  function automatic logic is_digit(input logic [4:0] code);
    is_digit = (code >= KEY_DIG0) && (code <= KEY_DIG9);
  endfunction

  function automatic logic [3:0] key_index(input logic [4:0] code);
    logic [4:0] k;
    k = code - KEY_DIG0;
    key_index = k[3:0];
  endfunction

  // Character selected by a digit key after sel presses
  function automatic logic [7:0] key_char(input logic [4:0] code, input logic [3:0] sel,
                                          input logic caps);
    logic [3:0] k;
    logic [7:0] base;
    k    = key_index(code);
    base = caps ? UPPER_BASE : LOWER_BASE;
    if (!is_digit(code)) begin
      key_char = CHAR_NUL;
    end else if (sel == KEY_SPAN[k]) begin
      key_char = DIGIT_BASE + {4'b0, k};
    end else if (k == 4'd0) begin
      key_char = (sel != 4'd0) ? CHAR_PLUS : CHAR_SPACE;
    end else if (k == 4'd1) begin
      key_char = (sel < 4'd10) ? ONE_SYMBOLS[sel] : DIGIT_BASE + 8'd1;
    end else begin
      key_char = base + LETTER_OFFSET[k] + {4'b0, sel};
    end
  endfunction

endpackage
`default_nettype wire

### rtl/multitap_keypad_text_entry_core.sv
// Multi-tap text entry for a 4x4 keypad. Feed one request per 1 ms tick carrying the key
// currently held (0 for none); every request yields exactly one result with an optional
// character write to the message store plus the cursor, length and mode state after that
// tick. A new request is taken every cycle while the output side does not stall; each
// one passes an input register, then one combinational update of the state registers
// and the result register. The repeat window and idle cursor advance use press_timeout
// ticks (register 0, byte address 0, reset 750); a hold needs more than twice that.
// Writes at position 512 or above are dropped.
`default_nettype none
module multitap_keypad_text_entry_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [4:0]  in_key_code,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_write_valid,
  output logic [8:0]       out_write_addr,
  output logic [7:0]       out_write_char,
  output logic [9:0]       out_cursor_pos,
  output logic [9:0]       out_message_length,
  output logic             out_writing_mode,
  output logic             out_caps_on,
  output logic [1:0]       out_view_mode,
  output logic             out_flashing_on,
  output logic [3:0]       out_speed_factor,
  output logic [1:0]       out_cursor_style,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [15:0] timeout_r;

  logic       req_valid_r;
  logic [4:0] req_key_r;
  logic       step_en;
  logic       in_accept;

  logic        out_valid_r;
  logic        wr_valid_r, wr_valid_nxt;
  logic [8:0]  wr_addr_r, wr_addr_nxt;
  logic [7:0]  wr_char_r, wr_char_nxt;

  logic [31:0] tick_r, tick_nxt;
  logic [31:0] press_r, press_nxt;
  logic [31:0] release_r, release_nxt;
  logic [4:0]  last_r, last_nxt;
  logic [4:0]  prior_r, prior_nxt;
  logic [9:0]  cursor_r, cursor_nxt;
  logic [9:0]  length_r, length_nxt;
  logic        writing_r, writing_nxt;
  logic        caps_r, caps_nxt;
  logic        held_r, held_nxt;
  logic        texp_r, texp_nxt;
  logic [3:0]  sym_r, sym_nxt;
  logic [1:0]  view_r, view_nxt;
  logic        flash_r, flash_nxt;
  logic [3:0]  speed_r, speed_nxt;
  logic [1:0]  look_r, look_nxt;

  logic        wr_req;
  logic [9:0]  wr_pos;
  logic [7:0]  wr_ch;
  logic [31:0] since_rel;
  logic [31:0] since_press;

  // Configuration
  assign pready = 1'b1;
  assign prdata = (paddr[2] == mkte_pkg::REG_PRESS_TIMEOUT) ? {16'b0, timeout_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= mkte_pkg::TIMEOUT_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == mkte_pkg::REG_PRESS_TIMEOUT) begin
      timeout_r <= pwdata[15:0];
    end
  end

  // Handshake: input register feeds result register
  assign step_en   = req_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = req_valid_r && !step_en;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        req_valid_r <= 1'b1;
      end else if (step_en) begin
        req_valid_r <= 1'b0;
      end
      out_valid_r <= step_en || (out_valid_r && out_stall);
    end
  end

  // Unknown codes count as no key
  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_key_r <= (in_key_code > mkte_pkg::KEY_HASH) ? mkte_pkg::KEY_NONE : in_key_code;
    end
  end

  assign tick_nxt    = tick_r + 32'd1;
  assign since_rel   = tick_nxt - release_r;
  assign since_press = tick_nxt - press_r;

  always_comb begin
    press_nxt   = press_r;
    release_nxt = release_r;
    last_nxt    = last_r;
    prior_nxt   = prior_r;
    cursor_nxt  = cursor_r;
    length_nxt  = length_r;
    writing_nxt = writing_r;
    caps_nxt    = caps_r;
    held_nxt    = held_r;
    texp_nxt    = texp_r;
    sym_nxt     = sym_r;
    view_nxt    = view_r;
    flash_nxt   = flash_r;
    speed_nxt   = speed_r;
    look_nxt    = look_r;
    wr_req      = 1'b0;
    wr_pos      = cursor_r;
    wr_ch       = mkte_pkg::CHAR_NUL;

    if (req_key_r == mkte_pkg::KEY_NONE) begin
      if (last_r != mkte_pkg::KEY_NONE) begin
        prior_nxt   = last_r;
        last_nxt    = mkte_pkg::KEY_NONE;
        release_nxt = tick_nxt;
      end else if (since_rel >= {16'b0, timeout_r} && !texp_r &&
                   mkte_pkg::is_digit(prior_r) && cursor_r < mkte_pkg::MSG_SIZE) begin
        // idle spell: advance past the last typed character
        cursor_nxt = cursor_r + 10'd1;
        look_nxt   = mkte_pkg::CUR_BLINK;
        texp_nxt   = 1'b1;
      end
    end else if (req_key_r == last_r) begin
      if (writing_r && since_press > {15'b0, timeout_r, 1'b0} && !held_r) begin
        held_nxt = 1'b1;
        if (mkte_pkg::is_digit(req_key_r)) begin
          wr_req = 1'b1;
          wr_ch  = mkte_pkg::DIGIT_BASE + {4'b0, mkte_pkg::key_index(req_key_r)};
        end
      end
    end else begin
      press_nxt = tick_nxt;
      if (writing_r) begin
        if (prior_r == req_key_r && last_r == mkte_pkg::KEY_NONE && !held_r &&
            since_rel < {16'b0, timeout_r}) begin
          sym_nxt = sym_r + 4'd1;
        end else begin
          sym_nxt = 4'd0;
          if (!texp_r && mkte_pkg::is_digit(prior_r) && last_r != mkte_pkg::KEY_D &&
              cursor_r < mkte_pkg::MSG_SIZE && cursor_r < length_r) begin
            cursor_nxt = cursor_r + 10'd1;
          end
          look_nxt = mkte_pkg::CUR_BLINK;
        end
        if (mkte_pkg::is_digit(req_key_r) &&
            sym_nxt > mkte_pkg::KEY_SPAN[mkte_pkg::key_index(req_key_r)]) begin
          sym_nxt = 4'd0;
        end
        held_nxt = 1'b0;
        texp_nxt = 1'b0;
        if (last_r != mkte_pkg::KEY_NONE) begin
          prior_nxt = last_r;
        end
        last_nxt = req_key_r;

        case (req_key_r)
          mkte_pkg::KEY_STAR: begin
            writing_nxt = 1'b0;
            look_nxt    = mkte_pkg::CUR_OFF;
          end
          mkte_pkg::KEY_A: begin
            if (cursor_nxt != 10'd0) begin
              cursor_nxt = cursor_nxt - 10'd1;
            end
          end
          mkte_pkg::KEY_B: begin
            if (cursor_nxt != length_r && cursor_nxt < mkte_pkg::MSG_SIZE) begin
              cursor_nxt = cursor_nxt + 10'd1;
            end
          end
          mkte_pkg::KEY_C: begin
            wr_req = 1'b1;
            if (cursor_nxt == length_r && cursor_nxt != 10'd0) begin
              // backspace at the end: terminate one position earlier
              wr_pos     = cursor_nxt - 10'd1;
              wr_ch      = mkte_pkg::CHAR_NUL;
              cursor_nxt = cursor_nxt - 10'd1;
            end else begin
              wr_pos = cursor_nxt;
              wr_ch  = mkte_pkg::CHAR_SPACE;
            end
          end
          mkte_pkg::KEY_D: begin
            caps_nxt = !caps_r;
          end
          mkte_pkg::KEY_HASH: begin
          end
          default: begin
            wr_req   = 1'b1;
            wr_pos   = cursor_nxt;
            wr_ch    = mkte_pkg::key_char(req_key_r, sym_nxt, caps_r);
            look_nxt = mkte_pkg::CUR_STEADY;
          end
        endcase
      end else begin
        last_nxt = req_key_r;
        case (req_key_r)
          mkte_pkg::KEY_HASH: begin
            writing_nxt = 1'b1;
            look_nxt    = mkte_pkg::CUR_BLINK;
            sym_nxt     = 4'd0;
            last_nxt    = mkte_pkg::KEY_NONE;
            prior_nxt   = mkte_pkg::KEY_NONE;
            if (cursor_r > length_r) begin
              cursor_nxt = length_r;
            end
          end
          mkte_pkg::KEY_A: begin
            view_nxt = (view_r == mkte_pkg::VIEW_PAGING) ? mkte_pkg::VIEW_STATIC
                                                         : mkte_pkg::VIEW_PAGING;
          end
          mkte_pkg::KEY_B: begin
            view_nxt = (view_r == mkte_pkg::VIEW_SCROLL) ? mkte_pkg::VIEW_STATIC
                                                         : mkte_pkg::VIEW_SCROLL;
          end
          mkte_pkg::KEY_C: begin
            view_nxt = (view_r == mkte_pkg::VIEW_ROTATE) ? mkte_pkg::VIEW_STATIC
                                                         : mkte_pkg::VIEW_ROTATE;
          end
          mkte_pkg::KEY_D: begin
            flash_nxt = !flash_r;
          end
          mkte_pkg::KEY_STAR: begin
          end
          default: begin
            speed_nxt = 4'(mkte_pkg::SPEED_TOP - req_key_r);
          end
        endcase
      end
    end

    // Message store write and length tracking
    wr_valid_nxt = 1'b0;
    wr_addr_nxt  = 9'd0;
    wr_char_nxt  = mkte_pkg::CHAR_NUL;
    if (wr_req && wr_pos < mkte_pkg::MSG_SIZE) begin
      wr_valid_nxt = 1'b1;
      wr_addr_nxt  = wr_pos[8:0];
      wr_char_nxt  = wr_ch;
      if (wr_ch == mkte_pkg::CHAR_NUL) begin
        if (wr_pos < length_r) begin
          length_nxt = wr_pos;
        end
      end else if (wr_pos == length_r) begin
        length_nxt = length_r + 10'd1;
      end
    end

    if (!writing_nxt) begin
      look_nxt = mkte_pkg::CUR_OFF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r     <= 32'd0;
      press_r    <= 32'd0;
      release_r  <= 32'd0;
      last_r     <= mkte_pkg::KEY_NONE;
      prior_r    <= mkte_pkg::KEY_NONE;
      cursor_r   <= 10'd0;
      length_r   <= 10'd0;
      writing_r  <= 1'b0;
      caps_r     <= 1'b0;
      held_r     <= 1'b0;
      texp_r     <= 1'b0;
      sym_r      <= 4'd0;
      view_r     <= mkte_pkg::VIEW_STATIC;
      flash_r    <= 1'b0;
      speed_r    <= mkte_pkg::SPEED_RESET;
      look_r     <= mkte_pkg::CUR_OFF;
      wr_valid_r <= 1'b0;
      wr_addr_r  <= 9'd0;
      wr_char_r  <= mkte_pkg::CHAR_NUL;
    end else if (step_en) begin
      tick_r     <= tick_nxt;
      press_r    <= press_nxt;
      release_r  <= release_nxt;
      last_r     <= last_nxt;
      prior_r    <= prior_nxt;
      cursor_r   <= cursor_nxt;
      length_r   <= length_nxt;
      writing_r  <= writing_nxt;
      caps_r     <= caps_nxt;
      held_r     <= held_nxt;
      texp_r     <= texp_nxt;
      sym_r      <= sym_nxt;
      view_r     <= view_nxt;
      flash_r    <= flash_nxt;
      speed_r    <= speed_nxt;
      look_r     <= look_nxt;
      wr_valid_r <= wr_valid_nxt;
      wr_addr_r  <= wr_addr_nxt;
      wr_char_r  <= wr_char_nxt;
    end
  end

  // State registers only move with a result, so they double as the result fields
  assign out_valid          = out_valid_r;
  assign out_write_valid    = wr_valid_r;
  assign out_write_addr     = wr_addr_r;
  assign out_write_char     = wr_char_r;
  assign out_cursor_pos     = cursor_r;
  assign out_message_length = length_r;
  assign out_writing_mode   = writing_r;
  assign out_caps_on        = caps_r;
  assign out_view_mode      = view_r;
  assign out_flashing_on    = flash_r;
  assign out_speed_factor   = speed_r;
  assign out_cursor_style   = look_r;

endmodule
`default_nettype wire

### rtl/mkte_checker.sv
`default_nettype none
module mkte_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        out_write_valid,
  input wire logic [8:0]  out_write_addr,
  input wire logic [7:0]  out_write_char,
  input wire logic [9:0]  out_cursor_pos,
  input wire logic [9:0]  out_message_length,
  input wire logic        out_writing_mode,
  input wire logic [1:0]  out_cursor_style
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_write_char) &&
      $stable(out_cursor_pos) && $stable(out_message_length))
    else $error("result changed while stalled");

  // Cursor is off whenever the view mode is shown
  a_view_cursor_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_writing_mode |-> out_cursor_style == mkte_pkg::CUR_OFF)
    else $error("cursor shown in view mode");

  // A terminating write never leaves the length past it
  a_nul_trims: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_write_valid && out_write_char == mkte_pkg::CHAR_NUL |->
      out_message_length <= {1'b0, out_write_addr})
    else $error("length beyond terminator");

  // A character write never ends exactly at the length
  a_char_extends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_write_valid && out_write_char != mkte_pkg::CHAR_NUL |->
      out_message_length != {1'b0, out_write_addr})
    else $error("length not extended past written character");

  // Idle write fields read zero
  a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_write_valid |->
      out_write_addr == 9'd0 && out_write_char == mkte_pkg::CHAR_NUL)
    else $error("write fields set without a write");

endmodule

bind multitap_keypad_text_entry_core mkte_checker u_mkte_checker (.*);
`default_nettype wire
